// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the interrupt controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Types and constants shared by the interrupt status/mask controller.
// ----------------------------------------------------------------------------
package isc_pkg;

	// Sizing of the source set and the event counters.
	localparam int NUM_SOURCES = 14;
	localparam int COUNT_WIDTH = 32;
	localparam int SRC_IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

	// Readout layout.
	localparam int RST_SW_BIT     = 16;
	localparam int CHIP_ID_SHIFT  = 28;
	localparam int CFG_IDX_W      = 2;

	// Function codes of an input item.
	localparam logic [1:0] FUNC_RAISE = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_WRITE = 2'd3;

	// Register select codes.
	localparam logic [2:0] SEL_STATUS  = 3'd0;
	localparam logic [2:0] SEL_MASK    = 3'd1;
	localparam logic [2:0] SEL_CHIP_ID = 3'd2;
	localparam logic [2:0] SEL_CONFIG  = 3'd3;
	localparam logic [2:0] SEL_COUNTER = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RST_SWITCH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 2'd1;

	localparam logic [3:0] VERSION_RESET = 4'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [13:0] event_mask;
		logic [2:0]  reg_select;
		logic [31:0] write_data;
		logic [3:0]  counter_index;
	} isc_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
	} isc_out_t;

	// Decoded operation of the item being executed.
	typedef struct packed {
		logic fire;
		logic raise;
		logic clear;
		logic rd;
		logic wr;
	} isc_op_t;

endpackage

// File: rtl/core/interrupt_status_mask_controller_unit.sv
// ----------------------------------------------------------------------------
// interrupt_status_mask_controller_unit
// Interrupt controller with status, enable mask and per-source event counters.
// ----------------------------------------------------------------------------
// Use:
//   The in channel takes one item per cycle unless stalled: a raise or clear
//   event, a register read or a register write. Each item gives exactly one
//   result on the out channel, carrying the read data and the irq level after
//   the item. The cfg channel writes the reset switch level (index 0) and the
//   console version (index 1); it is always ready and should be used while
//   idle. An accepted item waits in the input register until the output
//   register is free; the state update and the result capture in the output
//   register then happen together. Throughput is one item per cycle while
//   the receiver does not stall, set by the status/counter update loop.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more item before in_ready drops.
//   Reset clears status, mask and counters, sets the version to 3 and the
//   reset switch level to 0, and empties both registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interrupt_status_mask_controller_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  isc_pkg::isc_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output isc_pkg::isc_out_t              out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [isc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import isc_pkg::*;

	logic                   valid_s1;
	isc_in_t                item_s1;
	logic                   advance;
	isc_op_t                op;
	logic [NUM_SOURCES-1:0] emask;
	logic [31:0]            cnt_rdata;
	logic [31:0]            read_data;
	logic                   irq_next;
	logic                   out_valid_q;
	isc_out_t               out_item_q;

	// Item in stage one moves on when the output register is free.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Function decode.
	always_comb begin
		op      = '0;
		op.fire = advance;
		unique case (item_s1.func)
			FUNC_RAISE: op.raise = 1'b1;
			FUNC_CLEAR: op.clear = 1'b1;
			FUNC_READ:  op.rd    = 1'b1;
			FUNC_WRITE: op.wr    = 1'b1;
			default:    op.rd    = 1'b0;
		endcase
	end

	assign emask = NUM_SOURCES'(item_s1.event_mask);

	isc_cnt_bank u_cnt_bank (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.emask         (emask),
		.counter_index (item_s1.counter_index),
		.cnt_rdata     (cnt_rdata)
	);

	assign cfg_ready = 1'b1;

	isc_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.item      (item_s1),
		.emask     (emask),
		.cnt_rdata (cnt_rdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.read_data (read_data),
		.irq_next  (irq_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.read_data <= read_data;
			out_item_q.irq       <= irq_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`ASSERT_ALWAYS(a_stall_cause, clk, arst_n,
		in_ready || (valid_s1 && out_valid_q && !out_ready))
	`ASSERT_NEXT(a_adv_result, clk, arst_n, advance, out_valid_q)

endmodule

// File: rtl/core/isc_cnt_bank.sv
// ----------------------------------------------------------------------------
// isc_cnt_bank
// Per-source event counters, bumped at the highest source of a raise.
// ----------------------------------------------------------------------------
module isc_cnt_bank (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isc_pkg::isc_op_t                    op,
	input  logic [isc_pkg::NUM_SOURCES-1:0]     emask,
	input  logic [3:0]                          counter_index,
	output logic [31:0]                         cnt_rdata
);
	import isc_pkg::*;

	logic [COUNT_WIDTH-1:0] counts_q [NUM_SOURCES];
	logic [SRC_IDX_W-1:0]   top_src;
	logic                   inc_en;

	// Priority encoder: index of the highest set source bit.
	function automatic logic [SRC_IDX_W-1:0] top_index(input logic [NUM_SOURCES-1:0] v);
		logic [SRC_IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (v[i]) begin
				idx = SRC_IDX_W'(i);
			end
		end
		return idx;
	endfunction

	assign top_src = top_index(emask);
	assign inc_en  = op.fire && op.raise && (emask != '0);

	// Counter array; wraps at its full width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				counts_q[i] <= '0;
			end
		end else if (inc_en) begin
			counts_q[top_src] <= counts_q[top_src] + COUNT_WIDTH'(1);
		end
	end

	// Counter readout, zero for an index past the last source.
	always_comb begin
		cnt_rdata = '0;
		if (32'(counter_index) < 32'(NUM_SOURCES)) begin
			cnt_rdata = 32'(counts_q[counter_index[SRC_IDX_W-1:0]]);
		end
	end

endmodule

// File: rtl/core/isc_regfile.sv
// ----------------------------------------------------------------------------
// isc_regfile
// Status, enable mask and configuration registers, read mux and irq level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isc_regfile (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isc_pkg::isc_op_t                    op,
	input  isc_pkg::isc_in_t                    item,
	input  logic [isc_pkg::NUM_SOURCES-1:0]     emask,
	input  logic [31:0]                         cnt_rdata,
	input  logic                                cfg_we,
	input  logic [isc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data,
	output logic [31:0]                         read_data,
	output logic                                irq_next
);
	import isc_pkg::*;

	logic [NUM_SOURCES-1:0] status_q;
	logic [NUM_SOURCES-1:0] status_d;
	logic [31:0]            mask_q;
	logic [31:0]            mask_d;
	logic                   rst_sw_q;
	logic [3:0]             version_q;
	logic [NUM_SOURCES-1:0] wr_clr;
	logic [3:0]             ver_m1;

	assign wr_clr = NUM_SOURCES'(item.write_data);

	// Next status and mask for the item being executed.
	always_comb begin
		status_d = status_q;
		mask_d   = mask_q;
		if (op.fire) begin
			if (op.raise) begin
				status_d = status_q | emask;
			end else if (op.clear) begin
				status_d = status_q & ~emask;
			end else if (op.wr) begin
				if (item.reg_select == SEL_STATUS) begin
					status_d = status_q & ~wr_clr;
				end else if (item.reg_select == SEL_MASK) begin
					mask_d = item.write_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			mask_q   <= '0;
		end else begin
			status_q <= status_d;
			mask_q   <= mask_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_sw_q  <= 1'b0;
			version_q <= VERSION_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_RST_SWITCH) begin
				rst_sw_q <= cfg_data[0];
			end else if (cfg_index == CFG_VERSION) begin
				version_q <= cfg_data[3:0];
			end
		end
	end

	assign ver_m1 = version_q - 4'd1;

	// Read mux; reads never change state, so current values are returned.
	always_comb begin
		read_data = '0;
		if (op.rd) begin
			unique case (item.reg_select)
				SEL_STATUS:  read_data = 32'(status_q) | (32'(rst_sw_q) << RST_SW_BIT);
				SEL_MASK:    read_data = mask_q;
				SEL_CHIP_ID: read_data = 32'(ver_m1) << CHIP_ID_SHIFT;
				SEL_CONFIG:  read_data = '0;
				SEL_COUNTER: read_data = cnt_rdata;
				default:     read_data = '0;
			endcase
		end
	end

	// Interrupt level after this item's update.
	assign irq_next = ((32'(status_d) & mask_d) != '0);

	`ASSERT_NEXT(a_clear_done, clk, arst_n, op.fire && op.clear,
		(status_q & $past(emask)) == '0)

endmodule
